@@ sv/sexpr_keyword_tokenizer_assert.svh @@
// ----------------------------------------------------------------------------
// sexpr_keyword_tokenizer assertion macros
// shared concurrent assertion forms for the tokenizer checkers
// ----------------------------------------------------------------------------
`ifndef SEXPR_KEYWORD_TOKENIZER_ASSERT_SVH
`define SEXPR_KEYWORD_TOKENIZER_ASSERT_SVH

// implication checked only outside reset
`define SKT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication checked only outside reset
`define SKT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// implication checked at every edge, reset included
`define SKT_ASSERT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) else $error(msg);

`endif

@@ sv/skt_pkg.sv @@
// ----------------------------------------------------------------------------
// skt_pkg
// types, constants and match tables of the s-expression keyword tokenizer
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int WORD_COUNT = 14;
  localparam int WORD_MAX   = 8;
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef logic [7:0] byte_t;
  typedef logic [4:0] ttype_t;
  typedef logic [3:0] pos_t;
  typedef logic [WORD_COUNT-1:0] mask_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_COMMENT = 2'd1,
    MODE_VAR     = 2'd2,
    MODE_TERM    = 2'd3
  } mode_t;

  localparam logic KIND_CHAR   = 1'b0;
  localparam logic KIND_FINISH = 1'b1;

  localparam ttype_t TYPE_OPEN      = 5'd0;
  localparam ttype_t TYPE_CLOSE     = 5'd1;
  localparam ttype_t TYPE_VAR       = 5'd2;
  localparam ttype_t TYPE_TERM      = 5'd3;
  localparam ttype_t TYPE_WORD_BASE = 5'd4;

  localparam byte_t CH_TAB      = 8'h09;
  localparam byte_t CH_LF       = 8'h0A;
  localparam byte_t CH_CR       = 8'h0D;
  localparam byte_t CH_SPACE    = 8'h20;
  localparam byte_t CH_LPAREN   = 8'h28;
  localparam byte_t CH_RPAREN   = 8'h29;
  localparam byte_t CH_SEMI     = 8'h3B;
  localparam byte_t CH_QMARK    = 8'h3F;
  localparam byte_t CH_UPPER_A  = 8'h41;
  localparam byte_t CH_UPPER_Z  = 8'h5A;
  localparam byte_t CASE_OFFSET = 8'h20;

  localparam mask_t ALL_WORDS = '1;
  localparam pos_t  POS_MAX   = '1;

  // keywords then operators, zero padded
  localparam byte_t WORD_TEXT [WORD_COUNT][WORD_MAX] = '{
    '{"d", "i", "s", "t", "i", "n", "c", "t"},
    '{"d", "o", "e", "s", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"g", "o", "a", "l", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "i", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"l", "e", "g", "a", "l", 8'h00, 8'h00, 8'h00},
    '{"n", "e", "x", "t", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"r", "o", "l", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"t", "e", "r", "m", "i", "n", "a", "l"},
    '{"t", "r", "u", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"b", "a", "s", "e", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"i", "n", "p", "u", "t", 8'h00, 8'h00, 8'h00},
    '{"<", "=", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"n", "o", "t", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
    '{"o", "r", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
  };

  localparam pos_t WORD_LEN [WORD_COUNT] = '{
    4'd8, 4'd4, 4'd4, 4'd4, 4'd5, 4'd4, 4'd4, 4'd8, 4'd4, 4'd4, 4'd5, 4'd2, 4'd3, 4'd2
  };

  typedef struct packed {
    logic   kind;
    byte_t  char_out;
    ttype_t token_type;
    logic   last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r1;
    result_t    r0;
  } push_t;

  function automatic byte_t lower_byte(input byte_t b);
    byte_t r;
    r = b;
    if (b >= CH_UPPER_A && b <= CH_UPPER_Z) begin
      r = b + CASE_OFFSET;
    end
    return r;
  endfunction

  // lowest matching word wins
  function automatic ttype_t word_type(input mask_t mask, input pos_t pos);
    ttype_t t;
    t = TYPE_TERM;
    for (int k = WORD_COUNT - 1; k >= 0; k--) begin
      if (mask[k] && pos == WORD_LEN[k]) begin
        t = TYPE_WORD_BASE + ttype_t'(k);
      end
    end
    return t;
  endfunction

endpackage

@@ sv/sexpr_keyword_tokenizer.sv @@
// ----------------------------------------------------------------------------
// sexpr_keyword_tokenizer
// s-expression tokenizer with streaming keyword and operator match
// ----------------------------------------------------------------------------
// usage:
//   slave side takes one text byte per beat; tlast marks the final byte of
//   the input, which closes any open variable or term
//   master side gives one result per beat: tuser 0 carries a lowercased
//   token character, tuser 1 a token finish with its type; tlast flags the
//   final result of an input byte
// path: a byte is held in the input register and its results are then
//   written to the result queue, whose head drives the master side
// throughput: one byte per cycle while tready is high and each byte gives
//   at most one result; a byte giving two results needs two output beats,
//   set by the single output port draining a four-entry result queue
// reset: scanner returns to idle between tokens, match state cleared,
//   input register and result queue emptied
// stall: when the receiver holds tready low the queue fills and s_tready
//   drops while the input register holds a byte and fewer than two queue
//   entries are free; nothing is lost
// ----------------------------------------------------------------------------
module sexpr_keyword_tokenizer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] text_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [7:0] char_out, [12:8] token_type, [15:13] zero
  output logic [0:0]  m_tuser,   // [0] kind
  output logic        m_tlast
);

  skt_pkg::push_t   push;
  skt_pkg::result_t head;
  logic             room2;

  skt_scan u_scan (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .room2    (room2),
    .push     (push)
  );

  skt_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .room2    (room2),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .head     (head)
  );

  assign m_tdata = {3'b000, head.token_type, head.char_out};
  assign m_tuser = head.kind;
  assign m_tlast = head.last;

endmodule

@@ sv/skt_scan.sv @@
// ----------------------------------------------------------------------------
// skt_scan
// input register, scanner state and per-byte result generation
// ----------------------------------------------------------------------------
module skt_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,
  input  logic                s_tlast,
  input  logic                room2,
  output skt_pkg::push_t      push
);

  logic                in_valid;
  skt_pkg::byte_t      in_byte;
  logic                in_eoi;
  skt_pkg::mode_t      mode;
  skt_pkg::mode_t      mode_next;
  skt_pkg::mask_t      mask;
  skt_pkg::mask_t      mask_next;
  skt_pkg::pos_t       pos;
  skt_pkg::pos_t       pos_next;

  logic                fire;
  logic                sep;
  logic                paren;
  logic                starts_term;
  logic                is_char;
  logic                term_match;
  skt_pkg::byte_t      ch;
  skt_pkg::mask_t      base_mask;
  skt_pkg::pos_t       base_pos;
  skt_pkg::mask_t      upd_mask;
  skt_pkg::pos_t       upd_pos;
  skt_pkg::ttype_t     type_now;
  skt_pkg::ttype_t     type_after;
  skt_pkg::ttype_t     type_bracket;
  skt_pkg::result_t    r0;
  skt_pkg::result_t    r1;
  logic [1:0]          n;

  assign fire     = in_valid && room2;
  assign s_tready = !in_valid || room2;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_valid <= 1'b1;
    end else if (fire) begin
      in_valid <= 1'b0;
    end
    if (s_tvalid && s_tready) begin
      in_byte <= s_tdata;
      in_eoi  <= s_tlast;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= skt_pkg::MODE_IDLE;
      mask <= skt_pkg::ALL_WORDS;
      pos  <= '0;
    end else if (fire) begin
      mode <= mode_next;
      mask <= mask_next;
      pos  <= pos_next;
    end
  end

  // byte classes and keyword match
  always_comb begin
    sep = in_byte == skt_pkg::CH_SPACE || in_byte == skt_pkg::CH_TAB ||
          in_byte == skt_pkg::CH_CR || in_byte == skt_pkg::CH_LF;
    paren = in_byte == skt_pkg::CH_LPAREN || in_byte == skt_pkg::CH_RPAREN;
    ch = skt_pkg::lower_byte(in_byte);
    starts_term = mode == skt_pkg::MODE_IDLE && !sep && !paren &&
                  in_byte != skt_pkg::CH_SEMI && in_byte != skt_pkg::CH_QMARK;
    is_char = starts_term ||
              ((mode == skt_pkg::MODE_VAR || mode == skt_pkg::MODE_TERM) && !sep && !paren);
    term_match = starts_term || (mode == skt_pkg::MODE_TERM && is_char);
    base_mask = starts_term ? skt_pkg::ALL_WORDS : mask;
    base_pos  = starts_term ? '0 : pos;
    for (int k = 0; k < skt_pkg::WORD_COUNT; k++) begin
      upd_mask[k] = base_mask[k] && base_pos < skt_pkg::WORD_LEN[k] &&
                    skt_pkg::WORD_TEXT[k][base_pos[2:0]] == ch;
    end
    upd_pos = (base_pos == skt_pkg::POS_MAX) ? base_pos : base_pos + 4'd1;
    type_now = (mode == skt_pkg::MODE_VAR) ? skt_pkg::TYPE_VAR :
               skt_pkg::word_type(mask, pos);
    type_after = term_match ? skt_pkg::word_type(upd_mask, upd_pos) : skt_pkg::TYPE_VAR;
    type_bracket = (in_byte == skt_pkg::CH_LPAREN) ? skt_pkg::TYPE_OPEN :
                   skt_pkg::TYPE_CLOSE;
  end

  // next state
  always_comb begin
    mode_next = mode;
    mask_next = mask;
    pos_next  = pos;
    unique case (mode)
      skt_pkg::MODE_IDLE: begin
        if (!sep) begin
          if (in_byte == skt_pkg::CH_SEMI) begin
            mode_next = skt_pkg::MODE_COMMENT;
          end else if (in_byte == skt_pkg::CH_QMARK) begin
            mode_next = skt_pkg::MODE_VAR;
          end else if (!paren) begin
            mode_next = skt_pkg::MODE_TERM;
          end
        end
      end
      skt_pkg::MODE_COMMENT: begin
        if (in_byte == skt_pkg::CH_LF) begin
          mode_next = skt_pkg::MODE_IDLE;
        end
      end
      skt_pkg::MODE_VAR, skt_pkg::MODE_TERM: begin
        if (sep || paren) begin
          mode_next = skt_pkg::MODE_IDLE;
        end
      end
      default: mode_next = skt_pkg::MODE_IDLE;
    endcase
    if (term_match) begin
      mask_next = upd_mask;
      pos_next  = upd_pos;
    end
    if (in_eoi) begin
      mode_next = skt_pkg::MODE_IDLE;
      mask_next = skt_pkg::ALL_WORDS;
      pos_next  = '0;
    end
  end

  // results of this beat
  always_comb begin
    r0 = '0;
    r1 = '0;
    n  = 2'd0;
    unique case (mode)
      skt_pkg::MODE_IDLE: begin
        if (in_byte == skt_pkg::CH_QMARK) begin
          if (in_eoi) begin
            r0.kind       = skt_pkg::KIND_FINISH;
            r0.token_type = skt_pkg::TYPE_VAR;
            n = 2'd1;
          end
        end else if (paren) begin
          r0.kind       = skt_pkg::KIND_FINISH;
          r0.token_type = type_bracket;
          n = 2'd1;
        end else if (starts_term) begin
          r0.kind     = skt_pkg::KIND_CHAR;
          r0.char_out = ch;
          n = 2'd1;
          if (in_eoi) begin
            r1.kind       = skt_pkg::KIND_FINISH;
            r1.token_type = type_after;
            n = 2'd2;
          end
        end
      end
      skt_pkg::MODE_COMMENT: n = 2'd0;
      skt_pkg::MODE_VAR, skt_pkg::MODE_TERM: begin
        if (sep || paren) begin
          r0.kind       = skt_pkg::KIND_FINISH;
          r0.token_type = type_now;
          n = 2'd1;
          if (paren) begin
            r1.kind       = skt_pkg::KIND_FINISH;
            r1.token_type = type_bracket;
            n = 2'd2;
          end
        end else begin
          r0.kind     = skt_pkg::KIND_CHAR;
          r0.char_out = ch;
          n = 2'd1;
          if (in_eoi) begin
            r1.kind       = skt_pkg::KIND_FINISH;
            r1.token_type = type_after;
            n = 2'd2;
          end
        end
      end
      default: n = 2'd0;
    endcase
    r0.last = n == 2'd1;
    r1.last = n == 2'd2;
  end

  always_comb begin
    push.count = fire ? n : 2'd0;
    push.r0    = r0;
    push.r1    = r1;
  end

endmodule

@@ sv/skt_fifo.sv @@
// ----------------------------------------------------------------------------
// skt_fifo
// result queue taking up to two results per cycle, one out per beat
// ----------------------------------------------------------------------------
module skt_fifo (
  input  logic              clk,
  input  logic              rst,
  input  skt_pkg::push_t    push,
  output logic              room2,
  output logic              m_tvalid,
  input  logic              m_tready,
  output skt_pkg::result_t  head
);

  skt_pkg::result_t                   slots [skt_pkg::FIFO_DEPTH];
  logic [skt_pkg::FIFO_PTR_W-1:0]     wptr;
  logic [skt_pkg::FIFO_PTR_W-1:0]     wptr_inc;
  logic [skt_pkg::FIFO_PTR_W-1:0]     rptr;
  logic [skt_pkg::FIFO_CNT_W-1:0]     cnt;
  logic [skt_pkg::FIFO_CNT_W-1:0]     cnt_next;
  logic                               pop;

  assign pop      = m_tvalid && m_tready;
  assign m_tvalid = cnt != '0;
  assign head     = slots[rptr];
  assign room2    = cnt <= skt_pkg::FIFO_CNT_W'(skt_pkg::FIFO_DEPTH - 2);
  assign wptr_inc = wptr + skt_pkg::FIFO_PTR_W'(1);
  assign cnt_next = cnt + skt_pkg::FIFO_CNT_W'(push.count) - skt_pkg::FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      cnt  <= '0;
    end else begin
      wptr <= wptr + skt_pkg::FIFO_PTR_W'(push.count);
      rptr <= rptr + skt_pkg::FIFO_PTR_W'(pop);
      cnt  <= cnt_next;
    end
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      slots[wptr] <= push.r0;
    end
    if (push.count == 2'd2) begin
      slots[wptr_inc] <= push.r1;
    end
  end

endmodule

@@ sv/skt_checker.sv @@
// ----------------------------------------------------------------------------
// skt_checker
// port-level checks of the tokenizer output stream
// ----------------------------------------------------------------------------
`include "sexpr_keyword_tokenizer_assert.svh"

module skt_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic [0:0]  m_tuser,
  input logic        m_tlast
);

  `SKT_ASSERT_IMP(a_finish_no_char, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'h00,
                  "finish beat with nonzero char")
  `SKT_ASSERT_IMP(a_char_no_type, m_tvalid && !m_tuser[0], m_tdata[15:8] == 8'h00,
                  "char beat with nonzero type")
  `SKT_ASSERT_IMP(a_type_range, m_tvalid && m_tuser[0],
                  m_tdata[12:8] <= 5'd17 && m_tdata[15:13] == 3'b000,
                  "token type out of range")
  `SKT_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
                   m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast),
                   "stalled result changed")
  `SKT_ASSERT_ALWAYS(a_reset_empty, $past(rst) && !rst, !m_tvalid,
                     "result shown right after reset")

endmodule

bind sexpr_keyword_tokenizer skt_checker u_skt_checker (.*);

@@ tb/sv/sexpr_keyword_tokenizer_tb.sv @@
// ----------------------------------------------------------------------------
// sexpr_keyword_tokenizer_tb
// Self-checking bench for the s-expression keyword tokenizer. A text stream
// goes in over the slave side, one byte per beat. A scoreboard tokenizes
// every accepted byte itself. Each result beat from the master side is
// checked against the oldest predicted beat. Stimulus is a directed opener
// followed by random token streams: keywords in mixed case, broken
// keywords, terms, variables, brackets, comments and noise bytes. The run
// moves through four traffic phases with different sender gaps and
// receiver stalls, and drains between phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sexpr_keyword_tokenizer_tb;

  localparam int             CYCLE_LIMIT  = 200000;
  localparam int             PHASE_COUNT  = 4;
  localparam int             TOTAL_ITEMS  = 1550;
  localparam int             DRAIN_CYCLES = 20;
  localparam skt_pkg::byte_t LOWER_A      = "a";
  localparam skt_pkg::byte_t LOWER_Z      = "z";

  localparam int unsigned SEND_IDLE_PCT [PHASE_COUNT] = '{0, 80, 0, 17};
  localparam int unsigned RECV_STALL_PCT [PHASE_COUNT] = '{0, 0, 80, 17};

  // opener: keyword with mixed case, empty variable closed by a bracket,
  // ';' and '?' inside a term, a comment, high and nul bytes, end mid-term
  localparam int             DIRECTED_LEN = 25;
  localparam skt_pkg::byte_t DIRECTED_TEXT [DIRECTED_LEN] = '{
    skt_pkg::CH_LPAREN, "D", "i", "s", "T", "i", "N", "c", "t", skt_pkg::CH_CR,
    skt_pkg::CH_QMARK, skt_pkg::CH_RPAREN, "[", skt_pkg::CH_SEMI, skt_pkg::CH_QMARK,
    "A", "@", skt_pkg::CH_LPAREN, skt_pkg::CH_SEMI, "Q", skt_pkg::CH_RPAREN,
    skt_pkg::CH_LF, 8'hFF, 8'h00, "Z"
  };

  typedef struct packed {
    skt_pkg::byte_t text;
    logic           eoi;
  } text_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = '0;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;   // [7:0] char_out, [12:8] token_type, [15:13] zero
  logic [0:0]  m_tuser;   // [0] kind
  logic        m_tlast;

  text_beat_t       pending_bytes [$];
  skt_pkg::result_t expected_results [$];

  skt_pkg::mode_t   scan_mode;
  skt_pkg::pos_t    match_pos;
  skt_pkg::mask_t   candidates;

  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  int          queued_items = 0;
  int          errors = 0;
  int          cycle_count = 0;

  sexpr_keyword_tokenizer uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------- scoreboard

  function automatic skt_pkg::result_t make_beat(input logic kind,
                                                 input skt_pkg::byte_t ch,
                                                 input skt_pkg::ttype_t ttype);
    skt_pkg::result_t r;
    r.kind       = kind;
    r.char_out   = ch;
    r.token_type = ttype;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic skt_pkg::ttype_t finished_type();
    skt_pkg::ttype_t t;
    logic            found;
    t = skt_pkg::TYPE_TERM;
    found = 1'b0;
    if (scan_mode == skt_pkg::MODE_VAR) begin
      t = skt_pkg::TYPE_VAR;
      found = 1'b1;
    end
    for (int k = 0; k < skt_pkg::WORD_COUNT; k++) begin
      if (!found && candidates[k] && match_pos == skt_pkg::WORD_LEN[k]) begin
        t = skt_pkg::TYPE_WORD_BASE + skt_pkg::ttype_t'(k);
        found = 1'b1;
      end
    end
    return t;
  endfunction

  task automatic match_step(input skt_pkg::byte_t ch);
    for (int k = 0; k < skt_pkg::WORD_COUNT; k++) begin
      if (!(match_pos < skt_pkg::WORD_LEN[k] &&
            skt_pkg::WORD_TEXT[k][match_pos[2:0]] == ch)) begin
        candidates[k] = 1'b0;
      end
    end
    if (match_pos != skt_pkg::POS_MAX) begin
      match_pos = match_pos + 1'b1;
    end
  endtask

  task automatic tokenize_byte(input skt_pkg::byte_t b, input logic eoi);
    skt_pkg::result_t step_out [$];
    logic             is_sep;
    logic             is_paren;
    skt_pkg::byte_t   ch;
    is_sep   = b == skt_pkg::CH_SPACE || b == skt_pkg::CH_TAB ||
               b == skt_pkg::CH_CR || b == skt_pkg::CH_LF;
    is_paren = b == skt_pkg::CH_LPAREN || b == skt_pkg::CH_RPAREN;
    ch       = (b >= skt_pkg::CH_UPPER_A && b <= skt_pkg::CH_UPPER_Z) ?
               b + skt_pkg::CASE_OFFSET : b;
    case (scan_mode)
      skt_pkg::MODE_VAR, skt_pkg::MODE_TERM: begin
        if (is_sep || is_paren) begin
          step_out.insert(step_out.size(),
                          make_beat(skt_pkg::KIND_FINISH, '0, finished_type()));
          scan_mode = skt_pkg::MODE_IDLE;
        end else begin
          if (scan_mode == skt_pkg::MODE_TERM) begin
            match_step(ch);
          end
          step_out.insert(step_out.size(), make_beat(skt_pkg::KIND_CHAR, ch, '0));
        end
      end
      skt_pkg::MODE_COMMENT: begin
        if (b == skt_pkg::CH_LF) begin
          scan_mode = skt_pkg::MODE_IDLE;
        end
      end
      default: begin
        if (!is_sep) begin
          if (b == skt_pkg::CH_SEMI) begin
            scan_mode = skt_pkg::MODE_COMMENT;
          end else if (b == skt_pkg::CH_QMARK) begin
            scan_mode = skt_pkg::MODE_VAR;
          end else if (!is_paren) begin
            scan_mode  = skt_pkg::MODE_TERM;
            match_pos  = '0;
            candidates = skt_pkg::ALL_WORDS;
            match_step(ch);
            step_out.insert(step_out.size(), make_beat(skt_pkg::KIND_CHAR, ch, '0));
          end
        end
      end
    endcase
    // bracket is a token of its own
    if (is_paren && scan_mode == skt_pkg::MODE_IDLE) begin
      step_out.insert(step_out.size(),
                      make_beat(skt_pkg::KIND_FINISH, '0,
                                (b == skt_pkg::CH_LPAREN) ? skt_pkg::TYPE_OPEN :
                                                            skt_pkg::TYPE_CLOSE));
    end
    if (eoi) begin
      if (scan_mode == skt_pkg::MODE_VAR || scan_mode == skt_pkg::MODE_TERM) begin
        step_out.insert(step_out.size(),
                        make_beat(skt_pkg::KIND_FINISH, '0, finished_type()));
      end
      scan_mode  = skt_pkg::MODE_IDLE;
      match_pos  = '0;
      candidates = skt_pkg::ALL_WORDS;
    end
    if (step_out.size() > 0) begin
      step_out[step_out.size() - 1].last = 1'b1;
    end
    foreach (step_out[i]) begin
      expected_results.insert(expected_results.size(), step_out[i]);
    end
  endtask

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive_text
    text_beat_t beat;
    logic       go;
    if (rst) begin
      s_tvalid   <= 1'b0;
      scan_mode  = skt_pkg::MODE_IDLE;
      match_pos  = '0;
      candidates = skt_pkg::ALL_WORDS;
    end else begin
      if (s_tvalid && s_tready) begin
        tokenize_byte(s_tdata, s_tlast);
      end
      if (!s_tvalid || s_tready) begin
        go = pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct;
        if (go) begin
          beat = pending_bytes.pop_front();
          s_tvalid <= 1'b1;
          s_tdata  <= beat.text;
          s_tlast  <= beat.eoi;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : watch_results
    skt_pkg::result_t got;
    skt_pkg::result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got.kind       = m_tuser[0];
        got.char_out   = m_tdata[7:0];
        got.token_type = m_tdata[12:8];
        got.last       = m_tlast;
        if (expected_results.size() == 0) begin
          errors++;
          $display("%0t: unexpected beat kind %0d char %h type %0d last %0d",
                   $time, got.kind, got.char_out, got.token_type, got.last);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            errors++;
            $display("%0t: mismatch expected kind %0d char %h type %0d last %0d",
                     $time, want.kind, want.char_out, want.token_type, want.last);
            $display("%0t:          actual   kind %0d char %h type %0d last %0d",
                     $time, got.kind, got.char_out, got.token_type, got.last);
          end
        end
      end
      m_tready <= $urandom_range(99) >= recv_stall_pct;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d beats outstanding", $time, expected_results.size());
      $display("FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  task automatic add_byte(input skt_pkg::byte_t b, input logic eoi);
    text_beat_t beat;
    beat.text = b;
    beat.eoi  = eoi;
    pending_bytes.insert(pending_bytes.size(), beat);
    queued_items++;
  endtask

  function automatic logic maybe_end();
    return $urandom_range(47) == 0;
  endfunction

  function automatic skt_pkg::byte_t pick_separator();
    skt_pkg::byte_t b;
    case ($urandom_range(3))
      0: b = skt_pkg::CH_SPACE;
      1: b = skt_pkg::CH_TAB;
      2: b = skt_pkg::CH_CR;
      default: b = skt_pkg::CH_LF;
    endcase
    return b;
  endfunction

  // any byte that keeps a token going; a token may not open with ';' or '?'
  function automatic skt_pkg::byte_t term_char(input logic first);
    skt_pkg::byte_t b;
    do begin
      b = $urandom_range(255);
    end while (b == skt_pkg::CH_SPACE || b == skt_pkg::CH_TAB ||
               b == skt_pkg::CH_CR || b == skt_pkg::CH_LF ||
               b == skt_pkg::CH_LPAREN || b == skt_pkg::CH_RPAREN ||
               (first && (b == skt_pkg::CH_SEMI || b == skt_pkg::CH_QMARK)));
    return b;
  endfunction

  task automatic add_delimiter();
    int unsigned pick;
    pick = $urandom_range(9);
    if (pick < 6) begin
      repeat ($urandom_range(2, 1)) add_byte(pick_separator(), maybe_end());
    end else if (pick < 9) begin
      add_byte($urandom_range(1) ? skt_pkg::CH_LPAREN : skt_pkg::CH_RPAREN, maybe_end());
    end
  endtask

  task automatic add_token();
    int unsigned    pick;
    int unsigned    k;
    int unsigned    len;
    skt_pkg::byte_t c;
    pick = $urandom_range(99);
    if (pick < 38) begin
      // keyword or operator, sometimes cut short or run on
      k   = $urandom_range(skt_pkg::WORD_COUNT - 1);
      len = skt_pkg::WORD_LEN[k];
      if (pick >= 30 && pick < 35 && len > 1) begin
        len = $urandom_range(len - 1, 1);
      end
      for (int i = 0; i < len; i++) begin
        c = skt_pkg::WORD_TEXT[k][i];
        if (c >= LOWER_A && c <= LOWER_Z && $urandom_range(1)) begin
          c = c - skt_pkg::CASE_OFFSET;
        end
        add_byte(c, 1'b0);
      end
      if (pick >= 35) begin
        add_byte(term_char(1'b0), maybe_end());
      end
      add_delimiter();
    end else if (pick < 53) begin
      len = ($urandom_range(15) == 0) ? $urandom_range(20, 9) : $urandom_range(6, 1);
      for (int i = 0; i < len; i++) begin
        add_byte(term_char(i == 0), maybe_end());
      end
      add_delimiter();
    end else if (pick < 65) begin
      add_byte(skt_pkg::CH_QMARK, maybe_end());
      len = $urandom_range(5);
      for (int i = 0; i < len; i++) begin
        add_byte(term_char(1'b0), maybe_end());
      end
      add_delimiter();
    end else if (pick < 77) begin
      add_byte($urandom_range(1) ? skt_pkg::CH_LPAREN : skt_pkg::CH_RPAREN, maybe_end());
    end else if (pick < 83) begin
      add_byte(skt_pkg::CH_SEMI, 1'b0);
      len = $urandom_range(8);
      repeat (len) begin
        do begin
          c = $urandom_range(255);
        end while (c == skt_pkg::CH_LF);
        add_byte(c, 1'b0);
      end
      add_byte(skt_pkg::CH_LF, maybe_end());
    end else begin
      add_byte($urandom_range(255), maybe_end());
    end
  endtask

  task automatic wait_drained();
    while (pending_bytes.size() != 0 || s_tvalid || expected_results.size() != 0) begin
      @(negedge clk);
    end
  endtask

  initial begin
    int phase_target;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int i = 0; i < DIRECTED_LEN; i++) begin
      add_byte(DIRECTED_TEXT[i], i == DIRECTED_LEN - 1);
    end
    wait_drained();

    phase_target = queued_items;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      @(negedge clk);
      send_idle_pct  = SEND_IDLE_PCT[p];
      recv_stall_pct = RECV_STALL_PCT[p];
      phase_target   = phase_target + (TOTAL_ITEMS - DIRECTED_LEN) / PHASE_COUNT;
      while (queued_items < phase_target) begin
        add_token();
      end
      // hold off until the tokenizer has drained
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
